// File: rtl/rgb_to_hsv_converter_assert.svh
// ============================================================================
// RGB to HSV converter assertion macros
// Shorthand for clocked implication checks; every check is disabled in reset.
// ============================================================================
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// same-cycle implication
`define RHC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgb_to_hsv_converter: same-cycle check failed");

// next-cycle implication
`define RHC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgb_to_hsv_converter: next-cycle check failed");

`endif

// File: rtl/rhc_pkg.sv
// ============================================================================
// rhc_pkg
// Widths, constants, codes and the reciprocal table of the RGB to HSV converter.
// ============================================================================
`default_nettype none

package rhc_pkg;

   localparam int CHAN_WIDTH     = 8;
   localparam int PIXEL_WIDTH    = 3 * CHAN_WIDTH;
   localparam int HUE_WIDTH      = 15;
   localparam int SAT_WIDTH      = 17;
   localparam int SAT_FRAC_BITS  = 16;
   localparam int HUE_NUM_WIDTH  = 20;   // 255 * 3840 fits in 20 bits
   localparam int HUE_QUO_WIDTH  = 12;   // quotient never exceeds 3840
   localparam int HUE_CALC_WIDTH = 17;   // signed hue before wrap

   localparam int HUE_GREEN_OFFSET = 7680;
   localparam int HUE_BLUE_OFFSET  = 15360;
   localparam int HUE_FULL_TURN    = 23040;
   localparam int SAT_ONE          = 65536;

   // reciprocal table: floor((2^RECIP_SHIFT - 1) / d), zero for d = 0
   localparam int RECIP_SHIFT   = 26;
   localparam int RECIP_WIDTH   = 26;
   localparam int RECIP_ENTRIES = 1 << CHAN_WIDTH;

   localparam int DIV_LATENCY = 3;

   typedef enum logic [2:0] {
      SECTOR_RED   = 3'b001,
      SECTOR_GREEN = 3'b010,
      SECTOR_BLUE  = 3'b100
   } sector_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] max_level;
      logic                  negative;
      sector_type            sector;
      logic                  gray;
   } side_type;

   typedef logic [RECIP_ENTRIES-1:0][RECIP_WIDTH-1:0] recip_table_type;

   // restoring long division of an all-ones numerator, done at elaboration
   function automatic recip_table_type build_recip_table();
      recip_table_type        tbl;
      logic [CHAN_WIDTH:0]    rem;
      logic [RECIP_WIDTH-1:0] quo;
      for (int d = 0; d < RECIP_ENTRIES; d++) begin
         rem = '0;
         quo = '0;
         for (int i = RECIP_WIDTH - 1; i >= 0; i--) begin
            rem = {rem[CHAN_WIDTH-1:0], 1'b1};
            if (d != 0 && rem >= (CHAN_WIDTH + 1)'(d)) begin
               rem    = rem - (CHAN_WIDTH + 1)'(d);
               quo[i] = 1'b1;
            end
         end
         tbl[d] = quo;
      end
      return tbl;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip_table();

endpackage

`default_nettype wire

// File: rtl/rgb_to_hsv_converter.sv
// ============================================================================
// rgb_to_hsv_converter
// Packed RGB pixel in, fixed-point hue, saturation and value out.
// ============================================================================
// One pixel is taken every clock while start is high; busy rises only while
// reset is held. Each result appears on the rsp_ ports with rsp_strobe high
// for one cycle, in input order, after passing through the registered stages
// for max/min and channel difference, the reciprocal divide (table read,
// multiply, remainder fix-up) and the hue offset and wrap. The receiver
// cannot hold results off and none are buffered.
`default_nettype none

`include "rgb_to_hsv_converter_assert.svh"

module rgb_to_hsv_converter
   import rhc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [PIXEL_WIDTH-1:0] req_packed_color,
   output logic                        rsp_strobe,
   output logic [HUE_WIDTH-1:0]        rsp_hue_fixed,
   output logic [SAT_WIDTH-1:0]        rsp_saturation_fixed,
   output logic [CHAN_WIDTH-1:0]       rsp_value_level
);

   logic [CHAN_WIDTH-1:0] red, green, blue, max_level, min_level, op_a, op_b;
   sector_type            sector;
   logic                  req_accept;

   logic                  s1_valid_ff, s1_valid_in;
   logic [CHAN_WIDTH-1:0] s1_max_ff, s1_max_in;
   logic [CHAN_WIDTH-1:0] s1_delta_ff, s1_delta_in;
   logic [CHAN_WIDTH-1:0] s1_mag_ff, s1_mag_in;
   logic                  s1_neg_ff, s1_neg_in;
   sector_type            s1_sector_ff, s1_sector_in;
   logic [HUE_NUM_WIDTH-1:0] hue_num;

   logic     [DIV_LATENCY-1:0] line_valid_ff, line_valid_in;
   side_type [DIV_LATENCY-1:0] line_side_ff, line_side_in;

   logic [SAT_WIDTH-1:0]     sat_quo;
   logic [HUE_QUO_WIDTH-1:0] hue_quo;
   side_type                 last_side;

   logic signed [HUE_CALC_WIDTH-1:0] hue_offset, hue_step, hue_sum, hue_wrapped;

   logic                  out_valid_ff, out_valid_in;
   logic [HUE_WIDTH-1:0]  out_hue_ff, out_hue_in;
   logic [SAT_WIDTH-1:0]  out_sat_ff, out_sat_in;
   logic [CHAN_WIDTH-1:0] out_value_ff, out_value_in;

   assign busy       = reset;
   assign req_accept = start & ~busy;

   // stage 1: largest channel, spread and signed channel difference
   always_comb begin
      red   = req_packed_color[3*CHAN_WIDTH-1 -: CHAN_WIDTH];
      green = req_packed_color[2*CHAN_WIDTH-1 -: CHAN_WIDTH];
      blue  = req_packed_color[CHAN_WIDTH-1 -: CHAN_WIDTH];

      priority if (red >= green && red >= blue) begin
         sector    = SECTOR_RED;
         max_level = red;
         op_a      = green;
         op_b      = blue;
      end else if (green >= blue) begin
         sector    = SECTOR_GREEN;
         max_level = green;
         op_a      = blue;
         op_b      = red;
      end else begin
         sector    = SECTOR_BLUE;
         max_level = blue;
         op_a      = red;
         op_b      = green;
      end

      min_level = red;
      if (green < min_level) min_level = green;
      if (blue < min_level) min_level = blue;

      s1_valid_in  = req_accept;
      s1_max_in    = max_level;
      s1_delta_in  = max_level - min_level;
      s1_neg_in    = op_a < op_b;
      s1_mag_in    = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
      s1_sector_in = sector;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_max_ff    <= s1_max_in;
      s1_delta_ff  <= s1_delta_in;
      s1_mag_ff    <= s1_mag_in;
      s1_neg_ff    <= s1_neg_in;
      s1_sector_ff <= s1_sector_in;
   end

   // mag * 3840 as a shift and subtract
   assign hue_num = (HUE_NUM_WIDTH'(s1_mag_ff) << 12) - (HUE_NUM_WIDTH'(s1_mag_ff) << 8);

   rhc_recip_div #(
      .NUM_WIDTH (CHAN_WIDTH),
      .NUM_SHIFT (SAT_FRAC_BITS),
      .QUO_WIDTH (SAT_WIDTH)
   ) u_sat_div (
      .clock (clock),
      .num   (s1_delta_ff),
      .den   (s1_max_ff),
      .quo   (sat_quo)
   );

   rhc_recip_div #(
      .NUM_WIDTH (HUE_NUM_WIDTH),
      .NUM_SHIFT (0),
      .QUO_WIDTH (HUE_QUO_WIDTH)
   ) u_hue_div (
      .clock (clock),
      .num   (hue_num),
      .den   (s1_delta_ff),
      .quo   (hue_quo)
   );

   // carry valid and side data alongside the divider stages
   always_comb begin
      line_valid_in[0]           = s1_valid_ff;
      line_side_in[0].max_level  = s1_max_ff;
      line_side_in[0].negative   = s1_neg_ff;
      line_side_in[0].sector     = s1_sector_ff;
      line_side_in[0].gray       = s1_delta_ff == '0;
      for (int i = 1; i < DIV_LATENCY; i++) begin
         line_valid_in[i] = line_valid_ff[i-1];
         line_side_in[i]  = line_side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
      end else begin
         line_valid_ff <= line_valid_in;
      end
      line_side_ff <= line_side_in;
   end

   assign last_side = line_side_ff[DIV_LATENCY-1];

   // final stage: sector offset, sign, wrap below zero, zero hue and saturation for gray
   always_comb begin
      unique case (last_side.sector)
         SECTOR_RED:   hue_offset = '0;
         SECTOR_GREEN: hue_offset = HUE_CALC_WIDTH'(HUE_GREEN_OFFSET);
         SECTOR_BLUE:  hue_offset = HUE_CALC_WIDTH'(HUE_BLUE_OFFSET);
         default:      hue_offset = '0;
      endcase
      hue_step = last_side.negative ? -signed'(HUE_CALC_WIDTH'(hue_quo))
                                    : signed'(HUE_CALC_WIDTH'(hue_quo));
      hue_sum  = hue_offset + hue_step;
      hue_wrapped = (hue_sum < 0) ? hue_sum + HUE_CALC_WIDTH'(HUE_FULL_TURN) : hue_sum;

      out_valid_in = line_valid_ff[DIV_LATENCY-1];
      out_hue_in   = last_side.gray ? '0 : HUE_WIDTH'(hue_wrapped);
      out_sat_in   = last_side.gray ? '0 : sat_quo;
      out_value_in = last_side.max_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_hue_ff   <= out_hue_in;
      out_sat_ff   <= out_sat_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_strobe           = out_valid_ff;
   assign rsp_hue_fixed        = out_hue_ff;
   assign rsp_saturation_fixed = out_sat_ff;
   assign rsp_value_level      = out_value_ff;

   `RHC_ASSERT_NEXT(a_strobe_follows_line, line_valid_ff[DIV_LATENCY-1], rsp_strobe)
   `RHC_ASSERT_NEXT(a_no_stray_strobe, !line_valid_ff[DIV_LATENCY-1], !rsp_strobe)
   `RHC_ASSERT_NOW(a_hue_in_turn, rsp_strobe,
                   rsp_hue_fixed < HUE_WIDTH'(HUE_FULL_TURN))
   `RHC_ASSERT_NOW(a_sat_in_range, rsp_strobe,
                   rsp_saturation_fixed <= SAT_WIDTH'(SAT_ONE))
   `RHC_ASSERT_NOW(a_black_is_zero, rsp_strobe && rsp_value_level == '0,
                   rsp_hue_fixed == '0 && rsp_saturation_fixed == '0)

endmodule

`default_nettype wire

// File: rtl/rhc_recip_div.sv
// ============================================================================
// rhc_recip_div
// Pipelined divide of (num << NUM_SHIFT) by an 8-bit divisor: table
// reciprocal, multiply, then one remainder check that adds the missing unit.
// ============================================================================
`default_nettype none

module rhc_recip_div
   import rhc_pkg::*;
#(
   parameter int NUM_WIDTH = CHAN_WIDTH,
   parameter int NUM_SHIFT = SAT_FRAC_BITS,
   parameter int QUO_WIDTH = SAT_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic [NUM_WIDTH-1:0]  num,
   input  wire logic [CHAN_WIDTH-1:0] den,
   output logic      [QUO_WIDTH-1:0]  quo
);

   localparam int PROD_WIDTH = NUM_WIDTH + RECIP_WIDTH;
   localparam int REM_WIDTH  = NUM_WIDTH + NUM_SHIFT;
   localparam int BACK_WIDTH = QUO_WIDTH + CHAN_WIDTH;
   localparam int WIDE_WIDTH = (REM_WIDTH > BACK_WIDTH) ? REM_WIDTH : BACK_WIDTH;
   localparam int QUO_LSB    = RECIP_SHIFT - NUM_SHIFT;

   logic [NUM_WIDTH-1:0]   num_d1_ff, num_d1_in, num_d2_ff, num_d2_in;
   logic [CHAN_WIDTH-1:0]  den_d1_ff, den_d1_in, den_d2_ff, den_d2_in;
   logic [RECIP_WIDTH-1:0] recip_d1_ff, recip_d1_in;
   logic [QUO_WIDTH-1:0]   quo0_d2_ff, quo0_d2_in, quo_ff, quo_in;
   logic [PROD_WIDTH-1:0]  prod;
   logic [BACK_WIDTH-1:0]  back;
   logic [WIDE_WIDTH-1:0]  rem;
   logic                   short_by_one;

   always_comb begin
      num_d1_in   = num;
      den_d1_in   = den;
      recip_d1_in = RECIP_TABLE[den];

      // estimate is the true quotient or one below it
      prod       = PROD_WIDTH'(num_d1_ff) * PROD_WIDTH'(recip_d1_ff);
      quo0_d2_in = prod[QUO_LSB +: QUO_WIDTH];
      num_d2_in  = num_d1_ff;
      den_d2_in  = den_d1_ff;

      back         = BACK_WIDTH'(quo0_d2_ff) * BACK_WIDTH'(den_d2_ff);
      rem          = (WIDE_WIDTH'(num_d2_ff) << NUM_SHIFT) - WIDE_WIDTH'(back);
      short_by_one = rem >= WIDE_WIDTH'(den_d2_ff);
      quo_in       = quo0_d2_ff + QUO_WIDTH'(short_by_one);
   end

   always_ff @(posedge clock) begin
      num_d1_ff   <= num_d1_in;
      den_d1_ff   <= den_d1_in;
      recip_d1_ff <= recip_d1_in;
      num_d2_ff   <= num_d2_in;
      den_d2_ff   <= den_d2_in;
      quo0_d2_ff  <= quo0_d2_in;
      quo_ff      <= quo_in;
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire
